[design/avwt_pkg.sv]
// ----------------------------------------------------------------------------
// avwt_pkg
// Shared types and constants for the affine volume warp with trilinear
// interpolation: register indexes, reset values and fixed field widths.
// ----------------------------------------------------------------------------
`default_nettype none

package avwt_pkg;

    localparam int COORD_W = 6;
    localparam int VOX_W   = 16;
    localparam int COEF_W  = 32;
    localparam int CFG_W   = 64;
    localparam int SIZE_W  = 9;
    localparam int BASE_W  = 8;
    localparam int PROD_W  = COEF_W + COORD_W + 1;
    localparam int P_W     = PROD_W + 2;

    typedef logic [2:0] reg_idx_t;

    localparam reg_idx_t REG_ROW0_A = 3'd0;
    localparam reg_idx_t REG_ROW0_B = 3'd1;
    localparam reg_idx_t REG_ROW1_A = 3'd2;
    localparam reg_idx_t REG_ROW1_B = 3'd3;
    localparam reg_idx_t REG_ROW2_A = 3'd4;
    localparam reg_idx_t REG_ROW2_B = 3'd5;
    localparam reg_idx_t REG_SIZE   = 3'd6;

    localparam logic [CFG_W-1:0] RST_ROW0_A = 64'h0000_0000_0001_0000;
    localparam logic [CFG_W-1:0] RST_ROW0_B = 64'h0;
    localparam logic [CFG_W-1:0] RST_ROW1_A = 64'h0001_0000_0000_0000;
    localparam logic [CFG_W-1:0] RST_ROW1_B = 64'h0;
    localparam logic [CFG_W-1:0] RST_ROW2_A = 64'h0;
    localparam logic [CFG_W-1:0] RST_ROW2_B = 64'h0000_0000_0001_0000;
    localparam logic [23:0]      RST_SIZE   = 24'h40_4040;

    localparam logic [VOX_W-1:0] SAT_MAX = 16'hFFFF;

    function automatic logic signed [PROD_W-1:0] coef_mul(
        input logic signed [COEF_W-1:0] c,
        input logic [COORD_W-1:0]       d
    );
        logic signed [PROD_W-1:0] ce;
        logic signed [PROD_W-1:0] de;
        ce = PROD_W'(c);
        de = PROD_W'({1'b0, d});
        return ce * de;
    endfunction

endpackage

`default_nettype wire

[design/affine_volume_warp_trilinear.sv]
// ----------------------------------------------------------------------------
// affine_volume_warp_trilinear
// Inverse-mapped 3-D affine warp of a 16-bit source volume with trilinear
// interpolation, rounding half up and saturation.
// ----------------------------------------------------------------------------
// Usage: the input channel (in_valid, in_stall) carries one item per
// transfer. With func 0 the item loads voxel_value at (coord_x, coord_y,
// coord_z); with func 1 it samples that destination voxel and produces one
// transfer of sample_value on the output channel (out_valid, out_stall).
// Loads produce no output. The user must write the matrix and sizes
// through cfg_write only when the block is idle; it is not checked.
// An item can enter every cycle while in_stall is low. A sample passes
// through stages 1 to 6 and the output register. The source volume sits
// in eight banks split by the parity of x, y and z, so all eight
// corners are read in the same cycle. At reset all pipeline valid bits
// clear and the registers take their default values; the volume itself
// is undefined until loaded. While a valid output is stalled the whole
// pipeline holds and in_stall is raised until the waiting result is taken.
// ----------------------------------------------------------------------------
`default_nettype none

module affine_volume_warp_trilinear #(
    parameter int MAX_SIZE_X = 64,
    parameter int MAX_SIZE_Y = 64,
    parameter int MAX_SIZE_Z = 64,
    parameter int FRAC_BITS  = 16
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              cfg_write,
    input  wire avwt_pkg::reg_idx_t                cfg_index,
    input  wire logic [avwt_pkg::CFG_W-1:0]        cfg_data,
    input  wire logic                              in_valid,
    output logic                                   in_stall,
    input  wire logic                              func,
    input  wire logic [avwt_pkg::COORD_W-1:0]      coord_x,
    input  wire logic [avwt_pkg::COORD_W-1:0]      coord_y,
    input  wire logic [avwt_pkg::COORD_W-1:0]      coord_z,
    input  wire logic [avwt_pkg::VOX_W-1:0]        voxel_value,
    output logic                                   out_valid,
    input  wire logic                              out_stall,
    output logic [avwt_pkg::VOX_W-1:0]             sample_value
);

    localparam int F     = FRAC_BITS;
    localparam int EW    = avwt_pkg::VOX_W + F;
    localparam int FW    = avwt_pkg::VOX_W + 2 * F;
    localparam int BDX   = (MAX_SIZE_X + 1) / 2;
    localparam int BDY   = (MAX_SIZE_Y + 1) / 2;
    localparam int BDZ   = (MAX_SIZE_Z + 1) / 2;
    localparam int BXW   = (BDX > 1) ? $clog2(BDX) : 1;
    localparam int BYW   = (BDY > 1) ? $clog2(BDY) : 1;
    localparam int BZW   = (BDZ > 1) ? $clog2(BDZ) : 1;
    localparam int AW    = BXW + BYW + BZW;
    localparam int DEPTH = 1 << AW;
    localparam int SW    = avwt_pkg::SIZE_W;
    localparam int CW    = avwt_pkg::COORD_W;
    localparam int VW    = avwt_pkg::VOX_W;
    localparam int PW    = avwt_pkg::P_W;
    localparam int BW    = avwt_pkg::BASE_W;

    // Configuration registers.
    logic [avwt_pkg::CFG_W-1:0] cfg_reg [6];
    logic [23:0]                size_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg[0] <= avwt_pkg::RST_ROW0_A;
            cfg_reg[1] <= avwt_pkg::RST_ROW0_B;
            cfg_reg[2] <= avwt_pkg::RST_ROW1_A;
            cfg_reg[3] <= avwt_pkg::RST_ROW1_B;
            cfg_reg[4] <= avwt_pkg::RST_ROW2_A;
            cfg_reg[5] <= avwt_pkg::RST_ROW2_B;
            size_reg   <= avwt_pkg::RST_SIZE;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                avwt_pkg::REG_ROW0_A: cfg_reg[0] <= cfg_data;
                avwt_pkg::REG_ROW0_B: cfg_reg[1] <= cfg_data;
                avwt_pkg::REG_ROW1_A: cfg_reg[2] <= cfg_data;
                avwt_pkg::REG_ROW1_B: cfg_reg[3] <= cfg_data;
                avwt_pkg::REG_ROW2_A: cfg_reg[4] <= cfg_data;
                avwt_pkg::REG_ROW2_B: cfg_reg[5] <= cfg_data;
                avwt_pkg::REG_SIZE:   size_reg   <= cfg_data[23:0];
                default:              ;
            endcase
        end
    end

    logic signed [avwt_pkg::COEF_W-1:0] coef [3][4];
    logic [SW-1:0]                      size_ax [3];
    logic [SW-1:0]                      size_max [3];
    logic [7:0]                         size_fld [3];

    always_comb
    begin
        for (int a = 0; a < 3; a++)
        begin
            coef[a][0] = cfg_reg[2 * a][31:0];
            coef[a][1] = cfg_reg[2 * a][63:32];
            coef[a][2] = cfg_reg[2 * a + 1][31:0];
            coef[a][3] = cfg_reg[2 * a + 1][63:32];
        end
        size_max[0] = SW'(MAX_SIZE_X);
        size_max[1] = SW'(MAX_SIZE_Y);
        size_max[2] = SW'(MAX_SIZE_Z);
        size_fld[0] = size_reg[7:0];
        size_fld[1] = size_reg[15:8];
        size_fld[2] = size_reg[23:16];
        for (int a = 0; a < 3; a++)
        begin
            if (size_fld[a] == 8'd0)
                size_ax[a] = SW'(1);
            else if (SW'(size_fld[a]) > size_max[a])
                size_ax[a] = size_max[a];
            else
                size_ax[a] = SW'(size_fld[a]);
        end
    end

    // Global pipeline advance.
    logic pipe_adv;
    logic out_v_reg;
    assign pipe_adv = !(out_v_reg && out_stall);
    assign in_stall = !pipe_adv;

    // Stage 1: coefficient products.
    logic                        s1_v_reg;
    logic                        s1_func_reg;
    logic [CW-1:0]               s1_x_reg, s1_y_reg, s1_z_reg;
    logic [VW-1:0]               s1_val_reg;
    logic signed [avwt_pkg::PROD_W-1:0] s1_prod_reg [3][3];
    logic signed [avwt_pkg::PROD_W-1:0] s1_prod_next [3][3];

    always_comb
    begin
        for (int a = 0; a < 3; a++)
        begin
            s1_prod_next[a][0] = avwt_pkg::coef_mul(coef[a][0], coord_x);
            s1_prod_next[a][1] = avwt_pkg::coef_mul(coef[a][1], coord_y);
            s1_prod_next[a][2] = avwt_pkg::coef_mul(coef[a][2], coord_z);
        end
    end

    // Stage 2: source point, bounds check, integer part and fraction.
    logic                 s2_v_reg;
    logic                 s2_func_reg;
    logic [CW-1:0]        s2_x_reg, s2_y_reg, s2_z_reg;
    logic [VW-1:0]        s2_val_reg;
    logic                 s2_oob_reg;
    logic                 s2_oob_next;
    logic [BW-1:0]        s2_base_reg [3];
    logic [BW-1:0]        s2_base_next [3];
    logic [F-1:0]         s2_frac_reg [3];
    logic [F-1:0]         s2_frac_next [3];
    logic signed [PW-1:0] pnt [3];
    logic [PW-1:0]        lim [3];

    always_comb
    begin
        s2_oob_next = 1'b0;
        for (int a = 0; a < 3; a++)
        begin
            pnt[a] = PW'(s1_prod_reg[a][0]) + PW'(s1_prod_reg[a][1])
                   + PW'(s1_prod_reg[a][2]) + PW'(coef[a][3]);
            lim[a] = PW'(size_ax[a] - SW'(1)) << F;
            if (pnt[a][PW-1] || (PW'(unsigned'(pnt[a])) > lim[a]))
                s2_oob_next = 1'b1;
            s2_base_next[a] = pnt[a][F+BW-1:F];
            s2_frac_next[a] = pnt[a][F-1:0];
        end
    end

    // Stage 3: parity-banked volume, one read per bank per cycle.
    logic             s3_v_reg;
    logic             s3_oob_reg;
    logic [F-1:0]     s3_frac_reg [3];
    logic [2:0]       s3_par_reg;
    logic [7:0]       s3_ok_reg;
    logic [7:0]       s3_ok_next;
    logic [VW-1:0]    bank_rd_reg [8];
    logic [SW-1:0]    xc [8];
    logic [SW-1:0]    yc [8];
    logic [SW-1:0]    zc [8];
    logic [AW-1:0]    raddr [8];
    logic [SW-1:0]    wx, wy, wz;
    logic             wr_ok;
    logic [2:0]       wr_bank;
    logic [AW-1:0]    waddr;

    always_comb
    begin
        for (int b = 0; b < 8; b++)
        begin
            xc[b] = SW'(s2_base_reg[0]) + SW'(s2_base_reg[0][0] ^ b[0]);
            yc[b] = SW'(s2_base_reg[1]) + SW'(s2_base_reg[1][0] ^ b[1]);
            zc[b] = SW'(s2_base_reg[2]) + SW'(s2_base_reg[2][0] ^ b[2]);
            s3_ok_next[b] = (xc[b] < size_ax[0]) && (yc[b] < size_ax[1])
                          && (zc[b] < size_ax[2]);
            raddr[b] = {zc[b][BZW:1], yc[b][BYW:1], xc[b][BXW:1]};
        end
        wx = SW'(s2_x_reg);
        wy = SW'(s2_y_reg);
        wz = SW'(s2_z_reg);
        wr_ok = s2_v_reg && !s2_func_reg && (wx < size_max[0])
              && (wy < size_max[1]) && (wz < size_max[2]);
        wr_bank = {wz[0], wy[0], wx[0]};
        waddr = {wz[BZW:1], wy[BYW:1], wx[BXW:1]};
    end

    for (genvar gb = 0; gb < 8; gb++)
    begin : g_bank
        logic [VW-1:0] mem [DEPTH];

        always_ff @(posedge clk)
        begin
            if (pipe_adv)
            begin
                if (wr_ok && (wr_bank == 3'(gb)))
                    mem[waddr] <= s2_val_reg;
                bank_rd_reg[gb] <= mem[raddr[gb]];
            end
        end
    end

    // Stage 4: corner selection and interpolation along x.
    logic                  s4_v_reg;
    logic                  s4_oob_reg;
    logic [F-1:0]          s4_fy_reg, s4_fz_reg;
    logic [EW-1:0]         s4_e_reg [4];
    logic [EW-1:0]         s4_e_next [4];
    logic [VW-1:0]         corner [8];
    logic [2:0]            cb [8];
    logic signed [EW+1:0]  ea [4];
    logic signed [EW+1:0]  eb [4];
    logic signed [EW+1:0]  et;
    logic signed [EW+1:0]  ep [4];

    always_comb
    begin
        for (int n = 0; n < 8; n++)
        begin
            cb[n] = s3_par_reg ^ 3'(n);
            corner[n] = s3_ok_reg[cb[n]] ? bank_rd_reg[cb[n]] : '0;
        end
        et = (EW+2)'(s3_frac_reg[0]);
        for (int m = 0; m < 4; m++)
        begin
            ea[m] = (EW+2)'(corner[2 * m]);
            eb[m] = (EW+2)'(corner[2 * m + 1]);
            ep[m] = (ea[m] <<< F) + (eb[m] - ea[m]) * et;
            s4_e_next[m] = ep[m][EW-1:0];
        end
    end

    // Stage 5: interpolation along y.
    logic                  s5_v_reg;
    logic                  s5_oob_reg;
    logic [F-1:0]          s5_fz_reg;
    logic [FW-1:0]         s5_f_reg [2];
    logic [FW-1:0]         s5_f_next [2];
    logic signed [FW+1:0]  fa [2];
    logic signed [FW+1:0]  fb [2];
    logic signed [FW+1:0]  ft;
    logic signed [FW+1:0]  fp [2];

    always_comb
    begin
        ft = (FW+2)'(s4_fy_reg);
        for (int k = 0; k < 2; k++)
        begin
            fa[k] = (FW+2)'(s4_e_reg[2 * k]);
            fb[k] = (FW+2)'(s4_e_reg[2 * k + 1]);
            fp[k] = (fa[k] <<< F) + (fb[k] - fa[k]) * ft;
            s5_f_next[k] = fp[k][FW-1:0];
        end
    end

    // Stage 6: interpolation along z, split into high and low parts.
    logic                    s6_v_reg;
    logic                    s6_oob_reg;
    logic [FW-1:0]           s6_hi_reg;
    logic [FW-1:0]           s6_hi_next;
    logic [2*F-1:0]          s6_lo_reg;
    logic [2*F-1:0]          s6_lo_next;
    logic signed [FW+1:0]    ha, hb, ht, hp;
    logic signed [2*F+1:0]   la, lb, lt, lp;

    always_comb
    begin
        ha = (FW+2)'(s5_f_reg[0][FW-1:F]);
        hb = (FW+2)'(s5_f_reg[1][FW-1:F]);
        ht = (FW+2)'(s5_fz_reg);
        hp = (ha <<< F) + (hb - ha) * ht;
        s6_hi_next = hp[FW-1:0];
        la = (2*F+2)'(s5_f_reg[0][F-1:0]);
        lb = (2*F+2)'(s5_f_reg[1][F-1:0]);
        lt = (2*F+2)'(s5_fz_reg);
        lp = (la <<< F) + (lb - la) * lt;
        s6_lo_next = lp[2*F-1:0];
    end

    // Output register: round half up and saturate; out of bounds gives zero.
    logic [VW-1:0]  out_val_reg;
    logic [VW-1:0]  out_val_next;
    logic [FW:0]    tsum;
    logic [FW:0]    trnd;
    logic [VW:0]    tval;

    always_comb
    begin
        tsum = (FW+1)'(s6_hi_reg) + (FW+1)'(s6_lo_reg >> F);
        trnd = tsum + ((FW+1)'(1) << (2 * F - 1));
        tval = trnd[FW:2*F];
        if (s6_oob_reg)
            out_val_next = '0;
        else if (tval > (VW+1)'(avwt_pkg::SAT_MAX))
            out_val_next = avwt_pkg::SAT_MAX;
        else
            out_val_next = tval[VW-1:0];
    end

    // Valid bits.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_v_reg  <= 1'b0;
            s2_v_reg  <= 1'b0;
            s3_v_reg  <= 1'b0;
            s4_v_reg  <= 1'b0;
            s5_v_reg  <= 1'b0;
            s6_v_reg  <= 1'b0;
            out_v_reg <= 1'b0;
        end
        else if (pipe_adv)
        begin
            s1_v_reg  <= in_valid;
            s2_v_reg  <= s1_v_reg;
            s3_v_reg  <= s2_v_reg && s2_func_reg;
            s4_v_reg  <= s3_v_reg;
            s5_v_reg  <= s4_v_reg;
            s6_v_reg  <= s5_v_reg;
            out_v_reg <= s6_v_reg;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (pipe_adv)
        begin
            s1_func_reg <= func;
            s1_x_reg    <= coord_x;
            s1_y_reg    <= coord_y;
            s1_z_reg    <= coord_z;
            s1_val_reg  <= voxel_value;
            s1_prod_reg <= s1_prod_next;

            s2_func_reg <= s1_func_reg;
            s2_x_reg    <= s1_x_reg;
            s2_y_reg    <= s1_y_reg;
            s2_z_reg    <= s1_z_reg;
            s2_val_reg  <= s1_val_reg;
            s2_oob_reg  <= s2_oob_next;
            s2_base_reg <= s2_base_next;
            s2_frac_reg <= s2_frac_next;

            s3_oob_reg  <= s2_oob_reg;
            s3_frac_reg <= s2_frac_reg;
            s3_par_reg  <= {s2_base_reg[2][0], s2_base_reg[1][0], s2_base_reg[0][0]};
            s3_ok_reg   <= s3_ok_next;

            s4_oob_reg  <= s3_oob_reg;
            s4_fy_reg   <= s3_frac_reg[1];
            s4_fz_reg   <= s3_frac_reg[2];
            s4_e_reg    <= s4_e_next;

            s5_oob_reg  <= s4_oob_reg;
            s5_fz_reg   <= s4_fz_reg;
            s5_f_reg    <= s5_f_next;

            s6_oob_reg  <= s5_oob_reg;
            s6_hi_reg   <= s6_hi_next;
            s6_lo_reg   <= s6_lo_next;

            out_val_reg <= out_val_next;
        end
    end

    assign out_valid    = out_v_reg;
    assign sample_value = out_val_reg;

    // A sample whose source point falls outside the volume must give zero.
    a_oob_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (pipe_adv && s6_v_reg && s6_oob_reg) |=> (out_valid && sample_value == '0))
        else $error("out-of-bounds sample did not give zero");

    // A result only appears after a sample sat in the last stage.
    a_out_origin: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(s6_v_reg))
        else $error("result appeared without a sample behind it");

    // The input is held back only while a finished result waits.
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> (out_valid && out_stall))
        else $error("input stalled without a waiting result");

endmodule

`default_nettype wire

[test/tb_affine_volume_warp_trilinear.sv]
// ----------------------------------------------------------------------------
// tb_affine_volume_warp_trilinear
// Self-checking testbench for the affine volume warp. Voxels are loaded, then
// destination voxels are sampled under many matrices and volume sizes. A
// scoreboard predicts each interpolated intensity and compares it with the
// output transfers in order. Both sides idle at random, and once the output
// is held off for a long stretch so that the block backs up.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_affine_volume_warp_trilinear;

    localparam int DIM     = 64;
    localparam int DEPTH   = DIM * DIM * DIM;
    localparam int WD_MAX  = 3000;
    localparam bit F_LOAD  = 1'b0;
    localparam bit F_SAMP  = 1'b1;

    class warp_scoreboard;
        logic [avwt_pkg::CFG_W-1:0] regs [0:6];
        logic [avwt_pkg::VOX_W-1:0] volume [0:DEPTH-1];
        bit                         loaded [0:DEPTH-1];
        logic [avwt_pkg::VOX_W-1:0] pending_samples [$];
        int                         errors;

        function new();
            regs[avwt_pkg::REG_ROW0_A] = avwt_pkg::RST_ROW0_A;
            regs[avwt_pkg::REG_ROW0_B] = avwt_pkg::RST_ROW0_B;
            regs[avwt_pkg::REG_ROW1_A] = avwt_pkg::RST_ROW1_A;
            regs[avwt_pkg::REG_ROW1_B] = avwt_pkg::RST_ROW1_B;
            regs[avwt_pkg::REG_ROW2_A] = avwt_pkg::RST_ROW2_A;
            regs[avwt_pkg::REG_ROW2_B] = avwt_pkg::RST_ROW2_B;
            regs[avwt_pkg::REG_SIZE]   = 64'(avwt_pkg::RST_SIZE);
            errors = 0;
        endfunction

        function int axis_size(int a);
            int s;
            s = int'(regs[avwt_pkg::REG_SIZE][8*a +: 8]);
            if (s == 0)
                s = 1;
            if (s > DIM)
                s = DIM;
            return s;
        endfunction

        function longint coef(int row, int col);
            logic [avwt_pkg::CFG_W-1:0] w;
            logic [31:0]                b;
            w = regs[row*2 + col/2];
            b = (col % 2) ? w[63:32] : w[31:0];
            return longint'($signed(b));
        endfunction

        function logic [127:0] voxel_at(int x, int y, int z);
            if (x >= axis_size(0) || y >= axis_size(1) || z >= axis_size(2))
                return 128'd0;
            return 128'(volume[(z*DIM + y)*DIM + x]);
        endfunction

        function logic [avwt_pkg::VOX_W-1:0] interpolate(int dx, int dy, int dz);
            longint       p;
            int           base [3];
            logic [127:0] fr [3];
            logic [127:0] acc;
            logic [127:0] w;
            acc = 0;
            for (int a = 0; a < 3; a++)
            begin
                p = coef(a, 0)*dx + coef(a, 1)*dy + coef(a, 2)*dz + coef(a, 3);
                if (p < 0 || p > (longint'(axis_size(a) - 1) <<< 16))
                    return '0;
                base[a] = int'(p >>> 16);
                fr[a] = 128'(p & 64'hFFFF);
            end
            for (int c = 0; c < 8; c++)
            begin
                w = (c[0] ? fr[0] : 128'd65536 - fr[0])
                  * (c[1] ? fr[1] : 128'd65536 - fr[1])
                  * (c[2] ? fr[2] : 128'd65536 - fr[2]);
                acc += w * voxel_at(base[0] + c[0], base[1] + c[1], base[2] + c[2]);
            end
            acc = (acc + (128'd1 << 47)) >> 48;
            if (acc > 128'(avwt_pkg::SAT_MAX))
                return avwt_pkg::SAT_MAX;
            return acc[avwt_pkg::VOX_W-1:0];
        endfunction

        function void note_transfer(bit f, int x, int y, int z,
                                    logic [avwt_pkg::VOX_W-1:0] v);
            if (f == F_LOAD)
            begin
                volume[(z*DIM + y)*DIM + x] = v;
                loaded[(z*DIM + y)*DIM + x] = 1'b1;
            end
            else
                pending_samples.insert(pending_samples.size(), interpolate(x, y, z));
        endfunction

        task report(string what, logic [avwt_pkg::VOX_W-1:0] got,
                    logic [avwt_pkg::VOX_W-1:0] want);
            $display("%0t mismatch: %s got %h expected %h", $realtime, what, got, want);
            errors++;
        endtask

        task check_sample(logic [avwt_pkg::VOX_W-1:0] got);
            logic [avwt_pkg::VOX_W-1:0] want;
            if (pending_samples.size() == 0)
                report("unexpected sample_value", got, '0);
            else
            begin
                want = pending_samples.pop_front();
                if (got !== want)
                    report("sample_value", got, want);
            end
        endtask
    endclass

    logic                          clk = 1'b0;
    logic                          rst_n = 1'b0;
    logic                          cfg_write = 1'b0;
    avwt_pkg::reg_idx_t            cfg_index = avwt_pkg::REG_ROW0_A;
    logic [avwt_pkg::CFG_W-1:0]    cfg_data = '0;
    logic                          in_valid = 1'b0;
    logic                          in_stall;
    logic                          func = 1'b0;
    logic [avwt_pkg::COORD_W-1:0]  coord_x = '0;
    logic [avwt_pkg::COORD_W-1:0]  coord_y = '0;
    logic [avwt_pkg::COORD_W-1:0]  coord_z = '0;
    logic [avwt_pkg::VOX_W-1:0]    voxel_value = '0;
    logic                          out_valid;
    logic                          out_stall = 1'b0;
    logic [avwt_pkg::VOX_W-1:0]    sample_value;

    warp_scoreboard sb = new();
    bit in_burst = 1'b0;
    int hold_requests = 0;
    int hold_served = 0;
    int hold_left = 0;
    int out_gap = 0;
    int out_count = 0;
    bit out_burst = 1'b0;
    int idle_cycles = 0;

    affine_volume_warp_trilinear dut (
        .clk(clk), .rst_n(rst_n),
        .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .in_valid(in_valid), .in_stall(in_stall), .func(func),
        .coord_x(coord_x), .coord_y(coord_y), .coord_z(coord_z),
        .voxel_value(voxel_value),
        .out_valid(out_valid), .out_stall(out_stall), .sample_value(sample_value)
    );

    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && !out_stall)
            begin
                sb.check_sample(sample_value);
                out_count++;
                if (out_count % 40 == 0)
                    out_burst = ($urandom_range(0, 2) == 0);
                out_gap = out_burst ? 0 : $urandom_range(0, 8);
            end
            if (hold_requests != hold_served)
            begin
                hold_served = hold_requests;
                hold_left = 250;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                out_stall <= 1'b1;
            end
            else if (out_gap > 0)
            begin
                out_gap--;
                out_stall <= 1'b1;
            end
            else
                out_stall <= 1'b0;
        end
    end

    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_write)
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= WD_MAX)
        begin
            $display("[affine_volume_warp_trilinear] ERROR");
            $finish;
        end
    end

    task automatic send_item(bit f, int x, int y, int z, logic [avwt_pkg::VOX_W-1:0] v);
        int gap;
        gap = in_burst ? 0 : $urandom_range(0, 8);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        func <= f;
        coord_x <= avwt_pkg::COORD_W'(x);
        coord_y <= avwt_pkg::COORD_W'(y);
        coord_z <= avwt_pkg::COORD_W'(z);
        voxel_value <= v;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        sb.note_transfer(f, x, y, z, v);
    endtask

    task automatic settle();
        in_valid <= 1'b0;
        @(posedge clk);
        while (sb.pending_samples.size() > 0)
            @(posedge clk);
        repeat (12) @(posedge clk);
    endtask

    task automatic write_matrix(logic [31:0] m [12], logic [23:0] sizes);
        for (int r = 0; r < 7; r++)
        begin
            cfg_index <= avwt_pkg::reg_idx_t'(r);
            cfg_data <= (r == avwt_pkg::REG_SIZE) ? 64'(sizes) : {m[2*r + 1], m[2*r]};
            sb.regs[r] = (r == avwt_pkg::REG_SIZE) ? 64'(sizes) : {m[2*r + 1], m[2*r]};
            cfg_write <= 1'b1;
            @(posedge clk);
        end
        cfg_write <= 1'b0;
        @(posedge clk);
    endtask

    task automatic fill_volume();
        int sx, sy, sz;
        sx = sb.axis_size(0);
        sy = sb.axis_size(1);
        sz = sb.axis_size(2);
        for (int z = 0; z < sz; z++)
            for (int y = 0; y < sy; y++)
                for (int x = 0; x < sx; x++)
                    if (!sb.loaded[(z*DIM + y)*DIM + x])
                        send_item(F_LOAD, x, y, z, avwt_pkg::VOX_W'($urandom));
    endtask

    function automatic int pick_coord(int s);
        if ($urandom_range(0, 3) == 0)
            return $urandom_range(0, DIM - 1);
        return $urandom_range(0, (s + 1 < DIM) ? s + 1 : DIM - 1);
    endfunction

    task automatic run_phase(logic [23:0] sizes, bit wild, int count, bit pressure);
        logic [31:0] m [12];
        int s [3];
        for (int a = 0; a < 3; a++)
        begin
            s[a] = int'(sizes[8*a +: 8]);
            s[a] = (s[a] == 0) ? 1 : ((s[a] > DIM) ? DIM : s[a]);
            for (int c = 0; c < 4; c++)
            begin
                if (wild)
                    m[4*a + c] = $urandom;
                else if (c == 3)
                    m[4*a + c] = $urandom_range(0, (s[a] + 1) << 16) - 32'h8000;
                else if (c == a)
                    m[4*a + c] = $urandom_range(0, 32'h20000);
                else
                    m[4*a + c] = $urandom_range(0, 32'h4000) - 32'h2000;
            end
        end
        settle();
        write_matrix(m, sizes);
        fill_volume();
        in_burst = pressure;
        if (pressure)
            hold_requests++;
        for (int i = 0; i < count; i++)
        begin
            if (i % 30 == 0 && !pressure)
                in_burst = ($urandom_range(0, 2) == 0);
            if ($urandom_range(0, 5) == 0)
                send_item(F_LOAD, $urandom_range(0, DIM - 1), $urandom_range(0, DIM - 1),
                          $urandom_range(0, DIM - 1), avwt_pkg::VOX_W'($urandom));
            else
                send_item(F_SAMP, pick_coord(s[0]), pick_coord(s[1]), pick_coord(s[2]),
                          avwt_pkg::VOX_W'($urandom));
        end
        in_burst = 1'b0;
    endtask

    initial
    begin
        logic [31:0] m [12];
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Identity with a half-voxel shift in x on a 4x4x4 volume.
        m = '{32'h10000, 0, 0, 32'h8000, 0, 32'h10000, 0, 0, 0, 0, 32'h10000, 0};
        write_matrix(m, 24'h04_0404);
        send_item(F_LOAD, 63, 63, 63, 16'hFFFF);
        send_item(F_LOAD, 63, 0, 0, 16'h0000);
        for (int z = 0; z < 4; z++)
            for (int y = 0; y < 4; y++)
                for (int x = 0; x < 4; x++)
                    send_item(F_LOAD, x, y, z, (x == 1) ? 16'hFFFF : 16'h0001);
        send_item(F_SAMP, 0, 0, 0, 16'hFFFF);
        send_item(F_SAMP, 1, 2, 3, 16'h0000);
        send_item(F_SAMP, 2, 3, 3, 16'h1234);
        send_item(F_SAMP, 3, 0, 0, 16'h0000);
        send_item(F_SAMP, 63, 63, 63, 16'h0000);
        settle();
        m = '{32'h10000, 0, 0, 0, 0, 32'h10000, 0, 0, 0, 0, 32'h10000, 32'h30000};
        write_matrix(m, 24'h04_0404);
        send_item(F_SAMP, 3, 3, 0, 16'h0000);
        send_item(F_SAMP, 0, 0, 1, 16'h0000);
        settle();
        m = '{32'h80000000, 32'h7FFFFFFF, 0, 0, 32'h7FFFFFFF, 0, 0, 32'h80000000,
              0, 0, 32'h10000, 0};
        write_matrix(m, 24'h04_0404);
        send_item(F_SAMP, 1, 0, 0, 16'h0000);
        send_item(F_SAMP, 0, 0, 0, 16'h0000);
        send_item(F_SAMP, 63, 63, 0, 16'h0000);

        run_phase(24'h02_0202, 1'b0, 100, 1'b0);
        run_phase(24'h00_0000, 1'b0, 60, 1'b0);
        run_phase(24'h02_01FF, 1'b0, 100, 1'b0);
        run_phase(24'h01_FF01, 1'b0, 120, 1'b1);
        run_phase(24'h05_0608, 1'b0, 150, 1'b0);
        run_phase(24'h40_0201, 1'b0, 100, 1'b0);
        run_phase(24'h04_0404, 1'b1, 80, 1'b0);
        run_phase(24'h05_0608, 1'b0, 120, 1'b0);

        settle();
        repeat (20) @(posedge clk);
        if (sb.errors == 0 && sb.pending_samples.size() == 0)
            $display("[affine_volume_warp_trilinear] OK");
        else
            $display("[affine_volume_warp_trilinear] ERROR");
        $finish;
    end

endmodule
